@@ hw/rtl/tnfa_pkg.sv @@
// shared types and constants of the thompson nfa builder
`timescale 1ns / 1ps
package tnfa_pkg;

  localparam int MAX_FRAGMENTS_DEF = 16;
  localparam int STATE_COUNT_DEF   = 256;
  localparam int QUEUE_DEPTH       = 2;

  localparam int CMD_W   = 3;
  localparam int SYM_W   = 8;
  localparam int KIND_W  = 2;
  localparam int STOUT_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LITERAL = 3'd0,
    CMD_UNION   = 3'd1,
    CMD_CONCAT  = 3'd2,
    CMD_STAR    = 3'd3,
    CMD_END     = 3'd4
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TRANS  = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // decoded work handed from the front to the back
  typedef enum logic [2:0] {
    OP_LITERAL,
    OP_UNION,
    OP_CONCAT,
    OP_STAR,
    OP_END,
    OP_ERROR
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             spill;
    logic [SYM_W-1:0] sym;
  } op_ctl_t;

  localparam int CTL_W = $bits(op_ctl_t);

endpackage

@@ hw/rtl/tnfa_if.sv @@
// valid/ready channels for tokens in and nfa results out
`timescale 1ns / 1ps
interface tnfa_cmd_if;
  import tnfa_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, output command, output symbol, input ready);
  modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface tnfa_res_if;
  import tnfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [STOUT_W-1:0] from_state;
  logic [STOUT_W-1:0] to_state;
  logic               is_epsilon;
  logic [SYM_W-1:0]   symbol_out;
  logic               last;

  modport source (output valid, output kind, output from_state, output to_state,
                  output is_epsilon, output symbol_out, output last, input ready);
  modport sink   (input valid, input kind, input from_state, input to_state,
                  input is_epsilon, input symbol_out, input last, output ready);
endinterface

@@ hw/rtl/thompson_nfa_from_postfix_unit.sv @@
// top level of the postfix regex to thompson nfa builder
//
//   channel  dir  payload                                               transaction
//   cmd_i    in   command[2:0] symbol[7:0]                              one token
//   res_o    out  kind[1:0] from_state to_state is_epsilon symbol_out last  one result
//
// literal, end and error tokens give a single result; concatenation reads the stack
// ram before its single result; union and star give four results, one result per
// cycle while the output register is free, through the single output register
// a 2-entry queue sits between classifier and executor so tokens keep coming
// while results stall; the output register holds under backpressure
// reset clears depth, state counter and control; stack entries are undefined
// until pushed, so no clearing pass is needed
`timescale 1ns / 1ps
module thompson_nfa_from_postfix_unit #(
  parameter int MAX_FRAGMENTS = tnfa_pkg::MAX_FRAGMENTS_DEF,
  parameter int STATE_COUNT   = tnfa_pkg::STATE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tnfa_cmd_if.sink   cmd_i,
  tnfa_res_if.source res_o
);
  import tnfa_pkg::*;

  localparam int SW = $clog2(STATE_COUNT);
  localparam int IW = $clog2(MAX_FRAGMENTS);
  localparam int QW = CTL_W + SW + IW;

  logic          f_valid, f_ready;
  op_ctl_t       f_ctl;
  logic [SW-1:0] f_s;
  logic [IW-1:0] f_idx;

  logic          q_valid, q_pop;
  logic [QW-1:0] q_data;
  op_ctl_t       q_ctl;
  logic [SW-1:0] q_s;
  logic [IW-1:0] q_idx;

  tnfa_front #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS),
    .STATE_COUNT   (STATE_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_ctl_o   (f_ctl),
    .push_s_o     (f_s),
    .push_idx_o   (f_idx)
  );

  tnfa_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   ({f_ctl, f_s, f_idx}),
    .out_valid_o (q_valid),
    .out_ready_i (q_pop),
    .out_data_o  (q_data)
  );

  assign q_ctl = op_ctl_t'(q_data[QW-1 -: CTL_W]);
  assign q_s   = q_data[IW +: SW];
  assign q_idx = q_data[IW-1:0];

  tnfa_back #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS),
    .STATE_COUNT   (STATE_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_pop_o   (q_pop),
    .head_ctl_i   (q_ctl),
    .head_s_i     (q_s),
    .head_idx_i   (q_idx),
    .res_o        (res_o)
  );

  // an accepted token is queued for the executor on the next cycle
  a_token_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> q_valid)
    else $error("accepted token missing from queue");

  a_error_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == KIND_ERROR |->
      res_o.last && res_o.from_state == '0 && res_o.to_state == '0 &&
      !res_o.is_epsilon && res_o.symbol_out == '0)
    else $error("error result carries stray fields");

  a_single_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind != KIND_TRANS |-> res_o.last && !res_o.is_epsilon)
    else $error("report or error not marked last");

  a_eps_unlabelled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.is_epsilon |-> res_o.kind == KIND_TRANS &&
      res_o.symbol_out == '0)
    else $error("epsilon move carries a label");

endmodule

@@ hw/rtl/tnfa_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tnfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tnfa_fifo.sv @@
// small register queue between the classifier and the executor
`timescale 1ns / 1ps
module tnfa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [NW-1:0]    fill_q;
  logic             push, pop;

  assign in_ready_o  = fill_q != NW'(DEPTH);
  assign out_valid_o = fill_q != '0;
  assign out_data_o  = mem_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wrap_inc(wptr_q);
      end
      if (pop) begin
        rptr_q <= wrap_inc(rptr_q);
      end
      if (push && !pop) begin
        fill_q <= NW'(fill_q + 1'b1);
      end else if (pop && !push) begin
        fill_q <= NW'(fill_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

endmodule

@@ hw/rtl/tnfa_front.sv @@
// token classifier: stack depth and state allocation, error detection
`timescale 1ns / 1ps
module tnfa_front #(
  parameter int MAX_FRAGMENTS = 16,
  parameter int STATE_COUNT   = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  tnfa_cmd_if.sink                             cmd_i,
  output logic                                 push_valid_o,
  input  logic                                 push_ready_i,
  output tnfa_pkg::op_ctl_t                    push_ctl_o,
  output logic [$clog2(STATE_COUNT)-1:0]       push_s_o,
  output logic [$clog2(MAX_FRAGMENTS)-1:0]     push_idx_o
);
  import tnfa_pkg::*;

  localparam int SW = $clog2(STATE_COUNT);
  localparam int NW = $clog2(STATE_COUNT + 1);
  localparam int IW = $clog2(MAX_FRAGMENTS);
  localparam int CW = $clog2(MAX_FRAGMENTS + 1);

  logic [CW-1:0] count_q, count_d;
  logic [NW-1:0] nfs_q, nfs_d;
  logic          accept, states_ok;
  op_e           op;
  logic [IW-1:0] idx;

  assign accept       = cmd_i.valid && push_ready_i;
  assign cmd_i.ready  = push_ready_i;
  assign push_valid_o = cmd_i.valid;
  assign states_ok    = nfs_q <= NW'(STATE_COUNT - 2);

  always_comb begin
    count_d = count_q;
    nfs_d   = nfs_q;
    op      = OP_ERROR;
    idx     = IW'(count_q - 2'd2);
    unique case (cmd_i.command)
      CMD_LITERAL: begin
        idx = IW'(count_q - 1'b1);
        if (count_q < CW'(MAX_FRAGMENTS) && states_ok) begin
          op      = OP_LITERAL;
          count_d = CW'(count_q + 1'b1);
          nfs_d   = NW'(nfs_q + 2'd2);
        end
      end
      CMD_UNION: begin
        if (count_q >= CW'(2) && states_ok) begin
          op      = OP_UNION;
          count_d = CW'(count_q - 1'b1);
          nfs_d   = NW'(nfs_q + 2'd2);
        end
      end
      CMD_CONCAT: begin
        if (count_q >= CW'(2)) begin
          op      = OP_CONCAT;
          count_d = CW'(count_q - 1'b1);
        end
      end
      CMD_STAR: begin
        if (count_q != '0 && states_ok) begin
          op    = OP_STAR;
          nfs_d = NW'(nfs_q + 2'd2);
        end
      end
      CMD_END: begin
        if (count_q != '0) begin
          op      = OP_END;
          count_d = '0;
          nfs_d   = '0;
        end
      end
      default: begin
        op = OP_ERROR;
      end
    endcase
  end

  assign push_ctl_o.op    = op;
  assign push_ctl_o.spill = count_q != '0;
  assign push_ctl_o.sym   = cmd_i.symbol;
  assign push_s_o         = SW'(nfs_q);
  assign push_idx_o       = idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      nfs_q   <= '0;
    end else if (accept) begin
      count_q <= count_d;
      nfs_q   <= nfs_d;
    end
  end

endmodule

@@ hw/rtl/tnfa_back.sv @@
// executor: fragment stack with cached top, result sequencing, output register
`timescale 1ns / 1ps
module tnfa_back #(
  parameter int MAX_FRAGMENTS = 16,
  parameter int STATE_COUNT   = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 head_valid_i,
  output logic                                 head_pop_o,
  input  tnfa_pkg::op_ctl_t                    head_ctl_i,
  input  logic [$clog2(STATE_COUNT)-1:0]       head_s_i,
  input  logic [$clog2(MAX_FRAGMENTS)-1:0]     head_idx_i,
  tnfa_res_if.source                           res_o
);
  import tnfa_pkg::*;

  localparam int SW = $clog2(STATE_COUNT);

  // top of stack lives in flops, the rest below it in the ram
  logic [SW-1:0]   top_start_q, top_start_d, top_accept_q, top_accept_d;
  logic [SW-1:0]   b_start_q, b_start_d, b_accept_q, b_accept_d;
  logic [SW-1:0]   s_q, s_d, f_q, head_f;
  op_e             op_q, op_d;
  logic [1:0]      beat_q, beat_d;
  logic            active_q, active_d;

  logic            ram_we, ram_re;
  logic [2*SW-1:0] ram_rdata;
  logic [SW-1:0]   a_start, a_accept;

  logic            slot_free, emit, pop;
  kind_e           e_kind;
  logic [SW-1:0]   e_from, e_to;
  logic            e_eps, e_last;
  logic [SYM_W-1:0] e_sym;

  logic            res_valid_q;
  kind_e           res_kind_q;
  logic [SW-1:0]   res_from_q, res_to_q;
  logic            res_eps_q, res_last_q;
  logic [SYM_W-1:0] res_sym_q;

  tnfa_ram #(
    .WIDTH (2 * SW),
    .DEPTH (MAX_FRAGMENTS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_idx_i),
    .wdata_i ({top_start_q, top_accept_q}),
    .re_i    (ram_re),
    .raddr_i (head_idx_i),
    .rdata_o (ram_rdata)
  );

  assign a_start   = ram_rdata[2*SW-1:SW];
  assign a_accept  = ram_rdata[SW-1:0];
  assign f_q       = SW'(s_q + 1'b1);
  assign head_f    = SW'(head_s_i + 1'b1);
  assign slot_free = !res_valid_q || res_o.ready;
  assign head_pop_o = pop;

  always_comb begin
    emit         = 1'b0;
    pop          = 1'b0;
    e_kind       = KIND_TRANS;
    e_from       = '0;
    e_to         = '0;
    e_eps        = 1'b0;
    e_sym        = '0;
    e_last       = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    active_d     = active_q;
    beat_d       = beat_q;
    op_d         = op_q;
    s_d          = s_q;
    b_start_d    = b_start_q;
    b_accept_d   = b_accept_q;
    top_start_d  = top_start_q;
    top_accept_d = top_accept_q;
    if (slot_free) begin
      if (active_q) begin
        emit  = 1'b1;
        e_eps = 1'b1;
        unique case (op_q)
          OP_UNION: begin
            unique case (beat_q)
              2'd1: begin e_from = s_q; e_to = a_start; end
              2'd2: begin e_from = b_accept_q; e_to = f_q; end
              default: begin e_from = a_accept; e_to = f_q; e_last = 1'b1; end
            endcase
          end
          OP_STAR: begin
            unique case (beat_q)
              2'd1: begin e_from = s_q; e_to = f_q; end
              2'd2: begin e_from = b_accept_q; e_to = b_start_q; end
              default: begin e_from = b_accept_q; e_to = f_q; e_last = 1'b1; end
            endcase
          end
          default: begin
            // concatenation: lower fragment arrives from the ram
            e_from      = a_accept;
            e_to        = b_start_q;
            e_last      = 1'b1;
            top_start_d = a_start;
          end
        endcase
        beat_d = beat_q + 1'b1;
        if (e_last) begin
          active_d = 1'b0;
        end
      end else if (head_valid_i) begin
        pop  = 1'b1;
        op_d = head_ctl_i.op;
        s_d  = head_s_i;
        unique case (head_ctl_i.op)
          OP_LITERAL: begin
            emit         = 1'b1;
            e_from       = head_s_i;
            e_to         = head_f;
            e_sym        = head_ctl_i.sym;
            e_last       = 1'b1;
            ram_we       = head_ctl_i.spill;
            top_start_d  = head_s_i;
            top_accept_d = head_f;
          end
          OP_UNION, OP_STAR: begin
            emit         = 1'b1;
            e_from       = head_s_i;
            e_to         = top_start_q;
            e_eps        = 1'b1;
            ram_re       = head_ctl_i.op == OP_UNION;
            b_start_d    = top_start_q;
            b_accept_d   = top_accept_q;
            top_start_d  = head_s_i;
            top_accept_d = head_f;
            active_d     = 1'b1;
            beat_d       = 2'd1;
          end
          OP_CONCAT: begin
            ram_re    = 1'b1;
            b_start_d = top_start_q;
            active_d  = 1'b1;
            beat_d    = 2'd0;
          end
          OP_END: begin
            emit   = 1'b1;
            e_kind = KIND_REPORT;
            e_from = top_start_q;
            e_to   = top_accept_q;
            e_last = 1'b1;
          end
          default: begin
            emit   = 1'b1;
            e_kind = KIND_ERROR;
            e_last = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      beat_q      <= '0;
      op_q        <= OP_ERROR;
      res_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      beat_q   <= beat_d;
      op_q     <= op_d;
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q          <= s_d;
    b_start_q    <= b_start_d;
    b_accept_q   <= b_accept_d;
    top_start_q  <= top_start_d;
    top_accept_q <= top_accept_d;
    if (emit) begin
      res_kind_q <= e_kind;
      res_from_q <= e_from;
      res_to_q   <= e_to;
      res_eps_q  <= e_eps;
      res_sym_q  <= e_sym;
      res_last_q <= e_last;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.kind       = res_kind_q;
  assign res_o.from_state = STOUT_W'(res_from_q);
  assign res_o.to_state   = STOUT_W'(res_to_q);
  assign res_o.is_epsilon = res_eps_q;
  assign res_o.symbol_out = res_sym_q;
  assign res_o.last       = res_last_q;

endmodule
